// ===== hw/rtl/bba_pkg.sv =====
// bba_pkg: shared constants and types for the buddy block allocator
// no dependencies
package bba_pkg;
	localparam int unsigned POOL_MAX_BLOCKS = 1024;
	localparam int unsigned LEVEL_COUNT = 11;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned OFF_W = 10;
	localparam int unsigned STATUS_W = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic [0:0] opcode;
		logic [SIZE_W-1:0] size_blocks;
		logic [OFF_W-1:0] block_offset;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0] granted_offset;
	} rsp_t;
endpackage

// ===== hw/rtl/bba_if.sv =====
// bba_if: valid/ready channel carrying one payload
// depends on nothing; payload type given by parameter
interface bba_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bba_list_mem.sv =====
// bba_list_mem: per-level free list storage, one write and one registered read port
// depends on nothing
module bba_list_mem #(
	parameter int unsigned LEVELS = 11,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned OFF_W = 10
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(LEVELS)-1:0] wr_lvl,
	input logic [$clog2(DEPTH)-1:0] wr_pos,
	input logic [OFF_W-1:0] wr_data,
	input logic [$clog2(LEVELS)-1:0] rd_lvl,
	input logic [$clog2(DEPTH)-1:0] rd_pos,
	output logic [OFF_W-1:0] rd_data
);
	localparam int unsigned LVL_W = $clog2(LEVELS);
	localparam int unsigned POS_W = $clog2(DEPTH);
	logic [OFF_W-1:0] mem_q [LEVELS*DEPTH];
	logic [LVL_W+POS_W-1:0] wa, ra;
	assign wa = {wr_lvl, wr_pos};
	assign ra = {rd_lvl, rd_pos};
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wa] <= wr_data;
		end
		rd_data <= mem_q[ra];
	end
endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// buddy_block_allocator: top level, sequencer over per-level free lists
// depends on bba_pkg, bba_if, bba_list_mem
//
// channel  dir  payload                                   transfer
// req      in   opcode, size_blocks, block_offset          valid & ready
// rsp      out  status, granted_offset                     valid & ready
// cfg      in   pool_blocks                                cfg_we
//
// one transaction at a time; ready only in idle
// alloc: scans up to the first non-empty level and pops it; split pushes one half per level
// free: per level, searches the list entry by entry (one read port) and shifts down each entry
//   above a removed buddy; worst case grows with list length
// pool write rebuilds lists level by level; reset state is the full pool
// result is held until taken; the next request waits until then
module buddy_block_allocator #(
	parameter int unsigned POOL_MAX_BLOCKS = bba_pkg::POOL_MAX_BLOCKS,
	parameter int unsigned LEVEL_COUNT = bba_pkg::LEVEL_COUNT
) (
	input logic clk,
	input logic arst_n,
	bba_if.sink req,
	bba_if.source rsp,
	input logic cfg_we,
	input logic [bba_pkg::SIZE_W-1:0] cfg_wdata
);
	localparam int unsigned LVL_W = $clog2(LEVEL_COUNT + 1);
	localparam int unsigned ML_W = $clog2(LEVEL_COUNT);
	localparam int unsigned POS_W = $clog2(POOL_MAX_BLOCKS);
	localparam int unsigned CNT_W = POS_W + 1;
	localparam int unsigned OW = bba_pkg::OFF_W;
	localparam int unsigned OW1 = OW + 1;
	localparam int unsigned SW = bba_pkg::SIZE_W;

	typedef enum logic [3:0] {
		S_IDLE, S_BUILD, S_ASCAN, S_APOP, S_AGRANT, S_SPLIT,
		S_FREAD, S_FCMP, S_FSHIFT, S_FSHW, S_FPUSH, S_RESP
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q [LEVEL_COUNT];
	logic [LVL_W-1:0] lim_q;
	logic [SW-1:0] pool_q;
	logic [LVL_W-1:0] lvl_q, idx_q;
	logic [OW-1:0] addr_q;
	logic [CNT_W-1:0] pos_q;
	logic [bba_pkg::STATUS_W-1:0] st_q;
	logic [OW-1:0] gr_q;
	logic rvalid_q;

	logic mwe;
	logic [ML_W-1:0] mwl, mrl;
	logic [POS_W-1:0] mwp, mrp;
	logic [OW-1:0] mwd, mrd;

	bba_list_mem #(.LEVELS(LEVEL_COUNT), .DEPTH(POOL_MAX_BLOCKS), .OFF_W(OW)) u_mem (
		.clk(clk), .wr_en(mwe), .wr_lvl(mwl), .wr_pos(mwp), .wr_data(mwd),
		.rd_lvl(mrl), .rd_pos(mrp), .rd_data(mrd)
	);

	// ceil(log2(size)) as a small priority search
	function automatic logic [LVL_W-1:0] ceil_lvl(input logic [SW-1:0] s);
		logic [LVL_W-1:0] k;
		k = '0;
		for (int i = SW - 1; i >= 0; i--) begin
			if (s > (SW'(1) << i) && k == '0) k = LVL_W'(i + 1);
		end
		return k;
	endfunction

	function automatic logic [LVL_W-1:0] floor_lim(input logic [SW-1:0] p);
		logic [LVL_W-1:0] k;
		k = '0;
		for (int i = 0; i < SW; i++) begin
			if (p[i]) k = LVL_W'(i + 1);
		end
		if (k > LVL_W'(LEVEL_COUNT)) k = LVL_W'(LEVEL_COUNT);
		return k;
	endfunction

	logic [ML_W-1:0] lv;
	logic [CNT_W-1:0] cur_cnt;
	logic [OW1-1:0] span;
	logic [OW-1:0] addr_sh, mrd_sh;
	logic mine, hit_lo, hit_hi, hit;
	logic [SW-1:0] pool_sat;
	assign lv = ML_W'(lvl_q);
	assign cur_cnt = cnt_q[lv];
	// span and level bits stay defined at the top level
	assign span = OW1'(1) << lvl_q;
	assign addr_sh = addr_q >> lvl_q;
	assign mrd_sh = mrd >> lvl_q;
	assign mine = addr_sh[0];
	assign hit_lo = (addr_q >= mrd) && (OW1'(addr_q - mrd) == span) && !mrd_sh[0] && mine;
	assign hit_hi = (mrd >= addr_q) && (OW1'(mrd - addr_q) == span) && mrd_sh[0] && !mine;
	assign hit = hit_lo || hit_hi;
	assign pool_sat = (cfg_wdata > SW'(POOL_MAX_BLOCKS)) ? SW'(POOL_MAX_BLOCKS) : cfg_wdata;

	always_comb begin
		mwe = 1'b0;
		mwl = lv;
		mwp = POS_W'(cur_cnt);
		mwd = addr_q;
		mrl = lv;
		mrp = POS_W'(pos_q);
		case (state_q)
			S_BUILD: mwe = pool_q[lv] && (lvl_q < lim_q);
			S_SPLIT, S_FPUSH: mwe = (cur_cnt < CNT_W'(POOL_MAX_BLOCKS));
			S_FSHW: begin
				mwe = 1'b1;
				mwp = POS_W'(pos_q);
				mwd = mrd;
			end
			S_FREAD: mrp = POS_W'(pos_q - 1'b1);
			S_FSHIFT: mrp = POS_W'(pos_q + 1'b1);
			S_APOP: mrp = POS_W'(cur_cnt - 1'b1);
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && !cfg_we;
	assign rsp.valid = rvalid_q;
	assign rsp.payload = '{status: st_q, granted_offset: gr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BUILD;
			for (int i = 0; i < LEVEL_COUNT; i++) cnt_q[i] <= '0;
			pool_q <= SW'(1024 > POOL_MAX_BLOCKS ? POOL_MAX_BLOCKS : 1024);
			lim_q <= floor_lim(SW'(1024 > POOL_MAX_BLOCKS ? POOL_MAX_BLOCKS : 1024));
			lvl_q <= LVL_W'(LEVEL_COUNT - 1);
			idx_q <= '0;
			addr_q <= '0;
			pos_q <= '0;
			st_q <= bba_pkg::ST_DONE;
			gr_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						pool_q <= pool_sat;
						lim_q <= floor_lim(pool_sat);
						for (int i = 0; i < LEVEL_COUNT; i++) cnt_q[i] <= '0;
						lvl_q <= LVL_W'(LEVEL_COUNT - 1);
						addr_q <= '0;
						state_q <= S_BUILD;
					end else if (req.valid) begin
						idx_q <= ceil_lvl(req.payload.size_blocks);
						lvl_q <= ceil_lvl(req.payload.size_blocks);
						addr_q <= req.payload.block_offset;
						gr_q <= '0;
						if (req.payload.size_blocks == '0) begin
							st_q <= bba_pkg::ST_ZERO;
							state_q <= S_RESP;
						end else if (req.payload.opcode == bba_pkg::OP_ALLOC) begin
							if (ceil_lvl(req.payload.size_blocks) >= lim_q) begin
								st_q <= bba_pkg::ST_FAIL;
								state_q <= S_RESP;
							end else begin
								st_q <= bba_pkg::ST_DONE;
								state_q <= S_ASCAN;
							end
						end else if (ceil_lvl(req.payload.size_blocks) >= lim_q) begin
							st_q <= bba_pkg::ST_DONE;
							state_q <= S_RESP;
						end else begin
							st_q <= bba_pkg::ST_DONE;
							pos_q <= cnt_q[ML_W'(ceil_lvl(req.payload.size_blocks))];
							state_q <= S_FREAD;
						end
					end
				end
				S_BUILD: begin
					// largest piece first, at the lowest offset
					if (pool_q[lv] && lvl_q < lim_q) begin
						cnt_q[lv] <= CNT_W'(1);
						addr_q <= addr_q + OW'(span);
					end
					if (lvl_q == '0) state_q <= S_IDLE;
					else lvl_q <= lvl_q - 1'b1;
				end
				S_ASCAN: begin
					if (lvl_q >= lim_q) begin
						st_q <= bba_pkg::ST_FAIL;
						state_q <= S_RESP;
					end else if (cur_cnt != '0) begin
						state_q <= S_APOP;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_APOP: begin
					cnt_q[lv] <= cur_cnt - 1'b1;
					state_q <= S_AGRANT;
				end
				S_AGRANT: begin
					addr_q <= mrd;
					if (lvl_q == idx_q) begin
						gr_q <= mrd;
						state_q <= S_RESP;
					end else begin
						lvl_q <= lvl_q - 1'b1;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					// keep the lower half, carry on with the upper
					if (cur_cnt < CNT_W'(POOL_MAX_BLOCKS)) cnt_q[lv] <= cur_cnt + 1'b1;
					if (lvl_q == idx_q) begin
						gr_q <= addr_q + OW'(span);
						state_q <= S_RESP;
					end else begin
						addr_q <= addr_q + OW'(span);
						lvl_q <= lvl_q - 1'b1;
					end
				end
				S_FREAD: begin
					// search from the head down
					if (pos_q == '0) begin
						state_q <= S_FPUSH;
					end else begin
						pos_q <= pos_q - 1'b1;
						state_q <= S_FCMP;
					end
				end
				S_FCMP: begin
					if (hit) begin
						if (hit_lo) addr_q <= mrd;
						state_q <= S_FSHIFT;
					end else begin
						state_q <= S_FREAD;
					end
				end
				S_FSHIFT: begin
					if (pos_q + 1'b1 >= cur_cnt) begin
						cnt_q[lv] <= cur_cnt - 1'b1;
						if (lvl_q + 1'b1 >= lim_q) begin
							state_q <= S_RESP;
						end else begin
							lvl_q <= lvl_q + 1'b1;
							pos_q <= cnt_q[ML_W'(lvl_q + 1'b1)];
							state_q <= S_FREAD;
						end
					end else begin
						state_q <= S_FSHW;
					end
				end
				S_FSHW: begin
					pos_q <= pos_q + 1'b1;
					state_q <= S_FSHIFT;
				end
				S_FPUSH: begin
					if (cur_cnt < CNT_W'(POOL_MAX_BLOCKS)) cnt_q[lv] <= cur_cnt + 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rvalid_q) begin
						rvalid_q <= 1'b1;
					end else if (rsp.ready) begin
						rvalid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result is offered only from the response state
	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> state_q == S_RESP) else $error("response valid outside response state");
	// a non-done status never carries an offset
	a_gr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status != bba_pkg::ST_DONE |-> rsp.payload.granted_offset == '0)
		else $error("offset on failed transaction");
	// a request is taken only when no result is pending
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !rsp.valid) else $error("request taken with pending result");
endmodule
